// ===== src/fbfl_pkg.sv =====
package fbfl_pkg;

   localparam int BLOCK_SIZE_W = 13;
   localparam int INDEX_W      = 8;
   localparam int OFFSET_W     = 20;
   localparam int FREE_W       = 9;
   localparam int STATUS_W     = 2;

   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 13'd64;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_LINK
   } state_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_EMPTY,
      RSP_REJECT,
      RSP_FREED,
      RSP_GRANT
   } rsp_sel_type;

   typedef struct packed {
      logic        init_step;
      logic        push;
      logic        pop;
      rsp_sel_type rsp_load;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic alloc_ok;
      logic free_ok;
   } stat_type;

endpackage

// ===== src/fbfl_req_if.sv =====
interface fbfl_req_if;
   import fbfl_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [INDEX_W-1:0] block_index;

   modport source (output valid, output func, output block_index, input ready);
   modport sink (input valid, input func, input block_index, output ready);

endinterface

// ===== src/fbfl_rsp_if.sv =====
interface fbfl_rsp_if;
   import fbfl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  granted_index;
   logic [OFFSET_W-1:0] byte_offset;
   logic [FREE_W-1:0]   blocks_free;

   modport source (
      output valid, output status, output granted_index, output byte_offset,
      output blocks_free, input ready
   );
   modport sink (
      input valid, input status, input granted_index, input byte_offset,
      input blocks_free, output ready
   );

endinterface

// ===== src/fbfl_ctrl.sv =====
module fbfl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_func,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  fbfl_pkg::stat_type stat,
   output fbfl_pkg::cmd_type  cmd
);
   import fbfl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.init_step = 1'b0;
      cmd.push      = 1'b0;
      cmd.pop       = 1'b0;
      cmd.rsp_load  = RSP_NONE;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_ALLOC) begin
                  if (stat.alloc_ok) begin
                     state_in = ST_LINK;
                  end else begin
                     cmd.rsp_load = RSP_EMPTY;
                  end
               end else if (stat.free_ok) begin
                  cmd.push     = 1'b1;
                  cmd.rsp_load = RSP_FREED;
               end else begin
                  cmd.rsp_load = RSP_REJECT;
               end
            end
         end
         ST_LINK: begin
            // link word of the old head is now out of the memory
            cmd.pop      = 1'b1;
            cmd.rsp_load = RSP_GRANT;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load != RSP_NONE) begin
         rsp_valid_in = 1'b1;
      end
   end

endmodule

// ===== src/fbfl_datapath.sv =====
module fbfl_datapath #(
   parameter int BLOCK_COUNT = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [fbfl_pkg::BLOCK_SIZE_W-1:0]      csr_wr_data,
   input  logic [fbfl_pkg::INDEX_W-1:0]           req_block_index,
   input  fbfl_pkg::cmd_type                      cmd,
   output fbfl_pkg::stat_type                     stat,
   output logic [fbfl_pkg::STATUS_W-1:0]          rsp_status,
   output logic [fbfl_pkg::INDEX_W-1:0]           rsp_granted_index,
   output logic [fbfl_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   output logic [fbfl_pkg::FREE_W-1:0]            rsp_blocks_free
);
   import fbfl_pkg::*;

   localparam int AW = $clog2(BLOCK_COUNT);
   localparam int HW = $clog2(BLOCK_COUNT + 1);
   localparam int PW = AW + BLOCK_SIZE_W;
   localparam logic [HW-1:0] COUNT_FULL = HW'(BLOCK_COUNT);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(BLOCK_COUNT - 1);

   logic [HW-1:0] link_mem [BLOCK_COUNT];
   logic [HW-1:0] link_rd_ff;

   logic [AW-1:0]           init_cnt_ff;
   logic [AW-1:0]           init_cnt_in;
   logic [HW-1:0]           head_ff;
   logic [HW-1:0]           head_in;
   logic [HW-1:0]           count_ff;
   logic [HW-1:0]           count_in;
   logic [BLOCK_SIZE_W-1:0] block_size_ff;
   logic [BLOCK_SIZE_W-1:0] block_size_in;

   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [INDEX_W-1:0]  index_ff;
   logic [INDEX_W-1:0]  index_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [FREE_W-1:0]   free_ff;
   logic [FREE_W-1:0]   free_in;

   logic [AW-1:0] head_addr;
   logic [AW-1:0] free_addr;
   logic [PW-1:0] product;

   assign head_addr = head_ff[AW-1:0];
   assign free_addr = AW'(req_block_index);
   assign product   = PW'(head_addr) * PW'(block_size_ff);

   assign stat.init_last = (init_cnt_ff == LAST_ADDR);
   assign stat.alloc_ok  = (count_ff != '0) && (head_ff < COUNT_FULL);
   assign stat.free_ok   = (count_ff < COUNT_FULL)
                        && ({24'd0, req_block_index} < 32'(BLOCK_COUNT));

   // link memory, initialized by a sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         link_mem[init_cnt_ff] <= HW'(init_cnt_ff) + HW'(1);
      end else if (cmd.push) begin
         link_mem[free_addr] <= head_ff;
      end
      link_rd_ff <= link_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff   <= '0;
         head_ff       <= '0;
         count_ff      <= COUNT_FULL;
         block_size_ff <= BLOCK_SIZE_RESET;
      end else begin
         init_cnt_ff   <= init_cnt_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         block_size_ff <= block_size_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      offset_ff <= offset_in;
      free_ff   <= free_in;
   end

   always_comb begin
      init_cnt_in   = cmd.init_step ? init_cnt_ff + AW'(1) : init_cnt_ff;
      block_size_in = csr_wr_en ? csr_wr_data : block_size_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      if (cmd.push) begin
         head_in  = HW'(req_block_index);
         count_in = count_ff + HW'(1);
      end else if (cmd.pop) begin
         head_in  = link_rd_ff;
         count_in = count_ff - HW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      index_in  = index_ff;
      offset_in = offset_ff;
      free_in   = free_ff;
      case (cmd.rsp_load)
         RSP_EMPTY: begin
            status_in = STATUS_EMPTY;
            index_in  = '0;
            offset_in = '0;
            free_in   = FREE_W'(count_ff);
         end
         RSP_REJECT: begin
            status_in = STATUS_REJECT;
            index_in  = '0;
            offset_in = '0;
            free_in   = FREE_W'(count_ff);
         end
         RSP_FREED: begin
            status_in = STATUS_DONE;
            index_in  = '0;
            offset_in = '0;
            free_in   = FREE_W'(count_ff + HW'(1));
         end
         RSP_GRANT: begin
            status_in = STATUS_DONE;
            index_in  = INDEX_W'(head_ff);
            offset_in = OFFSET_W'(product);
            free_in   = FREE_W'(count_ff - HW'(1));
         end
         default: begin
         end
      endcase
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = index_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_blocks_free   = free_ff;

endmodule

// ===== src/fixed_block_free_list_allocator.sv =====
// Pool of BLOCK_COUNT equal-size blocks kept on a free list with one link word per
// block in a synchronous memory. A free request is answered from the idle state; an
// allocate also passes the link state, since the head's link word has to come out of
// the link memory before the head can move; one request is in work at a time, and a
// new request is taken while the previous result is being taken. After reset the
// block sweeps each link entry with req ready low; csr writes are taken at any time.
module fixed_block_free_list_allocator #(
   parameter int BLOCK_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fbfl_pkg::BLOCK_SIZE_W-1:0] csr_wr_data,
   fbfl_req_if.sink                          req_chan,
   fbfl_rsp_if.source                        rsp_chan
);
   import fbfl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbfl_datapath #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_block_index   (req_chan.block_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_chan.status),
      .rsp_granted_index (rsp_chan.granted_index),
      .rsp_byte_offset   (rsp_chan.byte_offset),
      .rsp_blocks_free   (rsp_chan.blocks_free)
   );

`ifndef SYNTHESIS
   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("request taken while a result is blocked");

   a_pop_after_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> $past(req_chan.valid && req_chan.ready && req_chan.func == FUNC_ALLOC))
      else $error("pop without an accepted allocate");

   a_push_leaves_block: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> stat.alloc_ok)
      else $error("pool not allocatable after a free");

   a_no_request_in_init: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !cmd.init_step)
      else $error("request ready during link sweep");
`endif

endmodule
